>>> hdl/sha1_pkg.sv
// shared types, codes and constants of the sha-1 stream hasher
package sha1_pkg;

   localparam logic [1:0] SEL_DATA = 2'd0;
   localparam logic [1:0] SEL_PAD  = 2'd1;
   localparam logic [1:0] SEL_ZERO = 2'd2;
   localparam logic [1:0] SEL_LEN  = 2'd3;

   localparam logic [1:0] GRP_CHOOSE = 2'd0;
   localparam logic [1:0] GRP_PAR_LO = 2'd1;
   localparam logic [1:0] GRP_MAJ    = 2'd2;
   localparam logic [1:0] GRP_PAR_HI = 2'd3;

   localparam int unsigned NUM_WORDS  = 5;
   localparam int unsigned SCHED_LEN  = 16;
   localparam logic [7:0]  PAD_BYTE   = 8'h80;

   localparam logic [4:0][31:0] INIT_VECTOR = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   typedef struct packed {
      logic       byte_wr;
      logic [1:0] byte_sel;
      logic [5:0] byte_addr;
      logic       len_inc;
      logic       len_clr;
      logic       load_work;
      logic       round_en;
      logic [1:0] round_grp;
      logic       chain_add;
      logic       chain_init;
      logic [2:0] out_idx;
   } dp_cmd_type;

   function automatic logic [31:0] round_const(input logic [1:0] grp);
      logic [31:0] k;
      case (grp)
         GRP_CHOOSE: k = 32'h5A827999;
         GRP_PAR_LO: k = 32'h6ED9EBA1;
         GRP_MAJ:    k = 32'h8F1BBCDC;
         GRP_PAR_HI: k = 32'hCA62C1D6;
         default:    k = 32'h5A827999;
      endcase
      return k;
   endfunction

endpackage

>>> hdl/sha1_datapath.sv
// sha-1 datapath: message schedule, round logic, chaining words and length count
module sha1_datapath
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic [7:0]  data_byte,
   output logic [31:0] digest_word
);

   logic [31:0] w_ff  [SCHED_LEN];
   logic [31:0] w_in  [SCHED_LEN];
   logic [31:0] cv_ff [NUM_WORDS];
   logic [31:0] cv_in [NUM_WORDS];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [60:0] len_ff, len_in;
   logic [63:0] bit_len;
   logic [7:0]  len_byte;
   logic [7:0]  wr_byte;
   logic [31:0] f_val;
   logic [31:0] t_sum;
   logic [31:0] w_next;

   assign bit_len  = {len_ff, 3'b000};
   assign len_byte = bit_len[{~cmd.byte_addr[2:0], 3'b000} +: 8];
   assign w_next   = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];

   always_comb begin
      case (cmd.byte_sel)
         SEL_DATA: wr_byte = data_byte;
         SEL_PAD:  wr_byte = PAD_BYTE;
         SEL_ZERO: wr_byte = 8'h00;
         SEL_LEN:  wr_byte = len_byte;
         default:  wr_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (cmd.round_grp)
         GRP_CHOOSE: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         GRP_MAJ:    f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default:    f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t_sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff
                  + round_const(cmd.round_grp) + w_ff[0];

   // schedule shift line doubles as the block buffer
   always_comb begin
      w_in = w_ff;
      if (cmd.round_en) begin
         for (int i = 0; i < SCHED_LEN - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[SCHED_LEN - 1] = {w_next[30:0], w_next[31]};
      end else if (cmd.byte_wr) begin
         w_in[cmd.byte_addr[5:2]][{~cmd.byte_addr[1:0], 3'b000} +: 8] = wr_byte;
      end
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.load_work) begin
         a_in = cv_ff[0];
         b_in = cv_ff[1];
         c_in = cv_ff[2];
         d_in = cv_ff[3];
         e_in = cv_ff[4];
      end else if (cmd.round_en) begin
         a_in = t_sum;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      cv_in = cv_ff;
      if (cmd.chain_init) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            cv_in[i] = INIT_VECTOR[i];
         end
      end else if (cmd.chain_add) begin
         cv_in[0] = cv_ff[0] + a_ff;
         cv_in[1] = cv_ff[1] + b_ff;
         cv_in[2] = cv_ff[2] + c_ff;
         cv_in[3] = cv_ff[3] + d_ff;
         cv_in[4] = cv_ff[4] + e_ff;
      end
   end

   always_comb begin
      len_in = len_ff;
      if (cmd.len_clr) begin
         len_in = '0;
      end else if (cmd.len_inc) begin
         len_in = len_ff + 61'd1;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            cv_ff[i] <= INIT_VECTOR[i];
         end
         len_ff <= '0;
      end else begin
         cv_ff  <= cv_in;
         len_ff <= len_in;
      end
   end

   assign digest_word = cv_ff[cmd.out_idx];

endmodule

>>> hdl/sha1_ctrl.sv
// sha-1 controller: byte intake, padding sequence, round count and digest output
module sha1_ctrl
   import sha1_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_byte_valid,
   input  logic       req_end_of_message,
   output logic       req_stall,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [2:0] rsp_word_index,
   output logic       rsp_last_word,
   output dp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_COMP   = 3'd1;
   localparam logic [2:0] ST_ADD    = 3'd2;
   localparam logic [2:0] ST_PAD80  = 3'd3;
   localparam logic [2:0] ST_PADZ   = 3'd4;
   localparam logic [2:0] ST_PADLEN = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   localparam logic [6:0] LAST_BYTE  = 7'd63;
   localparam logic [6:0] LEN_START  = 7'd56;
   localparam logic [6:0] BLOCK_SIZE = 7'd64;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [2:0] LAST_IDX   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [6:0] fill_ff, fill_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] idx_ff, idx_in;
   logic       eom_pend_ff, eom_pend_in;
   logic       extra_ff, extra_in;
   logic       final_ff, final_in;
   logic       req_take;
   logic [6:0] zero_target;

   assign req_stall      = (state_ff != ST_IDLE);
   assign req_take       = req_valid && !req_stall;
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == LAST_IDX);
   assign zero_target    = extra_ff ? BLOCK_SIZE : LEN_START;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      round_in    = round_ff;
      idx_in      = idx_ff;
      eom_pend_in = eom_pend_ff;
      extra_in    = extra_ff;
      final_in    = final_ff;

      cmd            = '0;
      cmd.byte_addr  = fill_ff[5:0];
      cmd.out_idx    = idx_ff;
      if (round_ff < 7'd20) begin
         cmd.round_grp = GRP_CHOOSE;
      end else if (round_ff < 7'd40) begin
         cmd.round_grp = GRP_PAR_LO;
      end else if (round_ff < 7'd60) begin
         cmd.round_grp = GRP_MAJ;
      end else begin
         cmd.round_grp = GRP_PAR_HI;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_byte_valid) begin
                  cmd.byte_wr  = 1'b1;
                  cmd.byte_sel = SEL_DATA;
                  cmd.len_inc  = 1'b1;
                  if (fill_ff == LAST_BYTE) begin
                     fill_in       = '0;
                     eom_pend_in   = req_end_of_message;
                     cmd.load_work = 1'b1;
                     state_in      = ST_COMP;
                  end else begin
                     fill_in = fill_ff + 7'd1;
                     if (req_end_of_message) begin
                        state_in = ST_PAD80;
                     end
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            cmd.byte_wr  = 1'b1;
            cmd.byte_sel = SEL_PAD;
            fill_in      = fill_ff + 7'd1;
            extra_in     = (fill_ff >= LEN_START);
            state_in     = ST_PADZ;
         end
         ST_PADZ: begin
            if (fill_ff == zero_target) begin
               if (extra_ff) begin
                  fill_in       = '0;
                  cmd.load_work = 1'b1;
                  state_in      = ST_COMP;
               end else begin
                  state_in = ST_PADLEN;
               end
            end else begin
               cmd.byte_wr  = 1'b1;
               cmd.byte_sel = SEL_ZERO;
               fill_in      = fill_ff + 7'd1;
            end
         end
         ST_PADLEN: begin
            cmd.byte_wr  = 1'b1;
            cmd.byte_sel = SEL_LEN;
            if (fill_ff == LAST_BYTE) begin
               fill_in       = '0;
               final_in      = 1'b1;
               cmd.load_work = 1'b1;
               state_in      = ST_COMP;
            end else begin
               fill_in = fill_ff + 7'd1;
            end
         end
         ST_COMP: begin
            cmd.round_en = 1'b1;
            if (round_ff == LAST_ROUND) begin
               round_in = '0;
               state_in = ST_ADD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_ADD: begin
            cmd.chain_add = 1'b1;
            if (final_ff) begin
               final_in = 1'b0;
               idx_in   = '0;
               state_in = ST_OUT;
            end else if (eom_pend_ff) begin
               eom_pend_in = 1'b0;
               state_in    = ST_PAD80;
            end else if (extra_ff) begin
               extra_in = 1'b0;
               state_in = ST_PADZ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (idx_ff == LAST_IDX) begin
                  idx_in         = '0;
                  fill_in        = '0;
                  cmd.chain_init = 1'b1;
                  cmd.len_clr    = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         round_ff    <= '0;
         idx_ff      <= '0;
         eom_pend_ff <= 1'b0;
         extra_ff    <= 1'b0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         round_ff    <= round_in;
         idx_ff      <= idx_in;
         eom_pend_ff <= eom_pend_in;
         extra_ff    <= extra_in;
         final_ff    <= final_in;
      end
   end

endmodule

>>> hdl/sha1_stream_hasher_core.sv
// top level of the sha-1 stream hasher
//
// req channel: one transaction per byte slot; req_byte_valid marks a message
// byte in req_data_byte, req_end_of_message closes the message (with or
// without a byte, so an empty message is allowed).
// rsp channel: after each closed message five transactions carry the digest,
// word 0 (most significant) first, rsp_last_word high on word 4.
// timing: a byte that does not complete a block is only written to the buffer. the 64th
// byte of a block starts the compression: the rounds on the single round unit, then
// the chaining add; no new byte is taken until both are done. at end of message
// the padding is written one byte a cycle up to the block end, then compressed;
// 56 or more pending bytes cost one more padded block.
// req_stall is high whenever the block is compressing, padding or sending.
// reset (synchronous) loads the initial vector and clears the byte and
// length counts. a stalled rsp transaction holds its word until taken; the
// next message is accepted after the fifth word has gone.
module sha1_stream_hasher_core
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   dp_cmd_type cmd;

   sha1_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .req_stall          (req_stall),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .cmd                (cmd)
   );

   sha1_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .digest_word (rsp_digest_word)
   );

   // no intake while a digest is being sent
   a_no_req_during_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while digest is being sent");

   // a closing transaction always leads into padding or compression
   a_eom_blocks_intake : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_of_message) |=> req_stall)
      else $error("intake still open after end of message");

   // the final word ends the digest burst
   a_burst_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> (!rsp_valid && !req_stall))
      else $error("digest burst did not end after the last word");

   // words leave in order
   a_word_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word order broken");

endmodule

>>> sim/tb_sha1_stream_hasher_core.sv
// self-checking testbench of the sha-1 stream hasher: byte streams in, digest words checked
`timescale 1ns / 1ps

module tb_sha1_stream_hasher_core;
   import sha1_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned ITEM_TARGET  = 330;
   localparam int unsigned IDLE_PERCENT = 19;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned SETTLE       = 300;
   localparam logic [31:0] K_CHOOSE     = 32'h5A827999;
   localparam logic [31:0] K_PAR_LO     = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ        = 32'h8F1BBCDC;
   localparam logic [31:0] K_PAR_HI     = 32'hCA62C1D6;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       eom;
      logic       drain;
   } byte_slot_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   byte_slot_type slot_q [$];
   digest_type    digest_q [$];
   byte_slot_type next_slot;
   digest_type    want;

   logic [31:0] hv [5];
   logic [7:0]  blk [64];
   int unsigned fill;
   logic [60:0] msg_bytes;

   int unsigned n_taken = 0;
   int unsigned n_bytes = 0;
   int unsigned n_msgs = 0;
   int unsigned n_words = 0;
   int unsigned n_errors = 0;
   int unsigned n_cycles = 0;
   int unsigned n_gen = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   logic        want_drain = 1'b0;
   logic        drain_set = 1'b0;
   logic        calm;

   assign calm = (n_taken >= 40) && (n_taken < 110);

   sha1_stream_hasher_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR cycle %0d: %s", n_cycles, what);
      n_errors++;
   endtask

   task automatic hash_restart();
      for (int i = 0; i < NUM_WORDS; i++) hv[i] = INIT_VECTOR[i];
      fill = 0;
      msg_bytes = '0;
   endtask

   task automatic run_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      int s;
      for (int r = 0; r < 16; r++) w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      a = hv[0];
      b = hv[1];
      c = hv[2];
      d = hv[3];
      e = hv[4];
      for (int r = 0; r < 80; r++) begin
         s = r % 16;
         if (r >= 16) begin
            x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[s];
            w[s] = {x[30:0], x[31]};
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_CHOOSE;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_PAR_LO;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = K_PAR_HI;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[s];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      hv[0] = hv[0] + a;
      hv[1] = hv[1] + b;
      hv[2] = hv[2] + c;
      hv[3] = hv[3] + d;
      hv[4] = hv[4] + e;
   endtask

   // advance the hash state by one transaction, queue the digest at end of message
   task automatic hash_take(input logic [7:0] data, input logic has_byte, input logic eom);
      logic [63:0] bit_len;
      digest_type  dw;
      if (has_byte) begin
         blk[fill] = data;
         fill++;
         msg_bytes = msg_bytes + 1'b1;
         if (fill == 64) begin
            run_compress();
            fill = 0;
         end
      end
      if (eom) begin
         blk[fill] = PAD_BYTE;
         fill++;
         if (fill > 56) begin
            while (fill < 64) begin
               blk[fill] = 8'h00;
               fill++;
            end
            run_compress();
            fill = 0;
         end
         while (fill < 56) begin
            blk[fill] = 8'h00;
            fill++;
         end
         bit_len = {msg_bytes, 3'b000};
         for (int i = 0; i < 8; i++) blk[56 + i] = bit_len[63 - 8*i -: 8];
         run_compress();
         for (int i = 0; i < NUM_WORDS; i++) begin
            dw.word  = hv[i];
            dw.index = 3'(i);
            dw.last  = (i == NUM_WORDS - 1);
            digest_q.push_back(dw);
         end
         hash_restart();
      end
   endtask

   task automatic add_slot(input logic [7:0] data, input logic has_byte, input logic eom);
      byte_slot_type it;
      it.data     = data;
      it.has_byte = has_byte;
      it.eom      = eom;
      it.drain    = want_drain;
      want_drain  = 1'b0;
      slot_q.push_back(it);
      if (has_byte || eom) n_gen++;
   endtask

   // message of len random bytes, closed on the last byte or by a byte-less end
   task automatic add_message(input int unsigned len, input logic close_on_byte);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) add_slot(8'($urandom), 1'b0, 1'b0);
         add_slot(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
      end
      if (!close_on_byte || len == 0) add_slot(8'($urandom), 1'b0, 1'b1);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            hash_take(req_data_byte, req_byte_valid, req_end_of_message);
            n_taken++;
            if (req_byte_valid) n_bytes++;
            if (req_end_of_message) n_msgs++;
         end
         if (!req_valid || !req_stall) begin
            if (slot_q.size() != 0 && !(slot_q[0].drain && digest_q.size() != 0)
                && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               next_slot = slot_q.pop_front();
               req_valid          <= 1'b1;
               req_data_byte      <= next_slot.data;
               req_byte_valid     <= next_slot.has_byte;
               req_end_of_message <= next_slot.eom;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && n_taken >= 200) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               report_mismatch($sformatf("unexpected digest word %h index %0d",
                                         rsp_digest_word, rsp_word_index));
            end else begin
               want = digest_q.pop_front();
               if (rsp_digest_word !== want.word)
                  report_mismatch($sformatf("digest_word %h, expected %h",
                                            rsp_digest_word, want.word));
               if (rsp_word_index !== want.index)
                  report_mismatch($sformatf("word_index %0d, expected %0d",
                                            rsp_word_index, want.index));
               if (rsp_last_word !== want.last)
                  report_mismatch($sformatf("last_word %b, expected %b",
                                            rsp_last_word, want.last));
               n_words++;
            end
         end
         rsp_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d digest words outstanding", digest_q.size());
         $display("FAIL sha1_stream_hasher_core");
         $finish;
      end
   end

   initial begin
      int unsigned len;
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      hash_restart();

      // directed: empty message, "abc", extremes of the byte, ignored slot
      add_slot(8'h00, 1'b0, 1'b1);
      add_slot(8'h61, 1'b1, 1'b0);
      add_slot(8'h62, 1'b1, 1'b0);
      add_slot(8'h63, 1'b1, 1'b1);
      add_slot(8'hFF, 1'b0, 1'b0);
      add_slot(8'h00, 1'b1, 1'b1);
      add_slot(8'hFF, 1'b1, 1'b0);
      add_slot(8'hFF, 1'b0, 1'b1);
      add_slot(8'hA5, 1'b0, 1'b1);
      add_slot(8'h5A, 1'b0, 1'b1);
      add_slot(8'h80, 1'b1, 1'b0);
      add_slot(8'h7F, 1'b1, 1'b1);

      // random messages, boundary lengths around the padding split included
      while (n_gen < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: len = 55;
            1: len = 56;
            2: len = 63;
            3: len = 64;
            4: len = $urandom_range(0, 3);
            5: len = $urandom_range(57, 70);
            default: len = $urandom_range(0, 40);
         endcase
         if (!drain_set && n_gen >= 150) begin
            want_drain = 1'b1;
            drain_set = 1'b1;
         end
         add_message(len, $urandom_range(0, 1));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (slot_q.size() != 0 || req_valid) @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d messages, %0d bytes, %0d digest words checked", n_msgs, n_bytes,
               n_words);
      $display("lengths included empty, 55, 56, 63, 64 bytes, with a long digest hold-off");
      if (n_errors == 0 && digest_q.size() == 0) begin
         $display("PASS sha1_stream_hasher_core");
      end else begin
         $display("FAIL sha1_stream_hasher_core");
      end
      $finish;
   end

endmodule
